// ===== sv/fdm_pkg.sv =====
package fdm_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int CORDIC_ITERS = 28;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 64;
    localparam int SIZE_BITS     = 13;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SRC_FOCAL      = 4'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SRC_CENTER     = 4'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DIST_K_LOW     = 4'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DIST_K_HIGH    = 4'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RECT_INV_FOCAL = 4'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RECT_CENTER    = 4'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SRC_WIDTH      = 4'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SRC_HEIGHT     = 4'd7;

    localparam logic [40:0] MAG_CAP = 41'h100_0000_0000;

    // data handed from cell to cell: sqrt state, then CORDIC and two dividers
    typedef struct packed {
        logic               neg_x;
        logic               neg_y;
        logic [30:0]        mag_x;
        logic [30:0]        mag_y;
        logic [62:0]        rem_sq;
        logic [62:0]        root;
        logic signed [40:0] cx;
        logic signed [40:0] cy;
        logic signed [32:0] cz;
        logic [31:0]        rem_x;
        logic [31:0]        rem_y;
        logic [30:0]        quo_x;
        logic [30:0]        quo_y;
    } cell_data_t;

    // atan(2^-i) in Q.30, rounded to nearest
    function automatic logic signed [32:0] atan_entry(input int idx);
        logic signed [32:0] val;
        case (idx)
            0:       val = 33'sd843314857;
            1:       val = 33'sd497837829;
            2:       val = 33'sd263043837;
            3:       val = 33'sd133525159;
            4:       val = 33'sd67021687;
            5:       val = 33'sd33543516;
            6:       val = 33'sd16775851;
            7:       val = 33'sd8388437;
            8:       val = 33'sd4194283;
            9:       val = 33'sd2097149;
            10:      val = 33'sd1048576;
            default: val = 33'sd1 <<< (30 - idx);
        endcase
        return val;
    endfunction

endpackage

// ===== sv/fdm_sqrt_cell.sv =====
module fdm_sqrt_cell
    import fdm_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       vld_in,
    input  cell_data_t d_in,
    output logic       vld_out,
    output cell_data_t d_out
);

    localparam logic [63:0] STEP_BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0] trial;
    logic        take;
    cell_data_t  d_next;
    cell_data_t  d_reg;
    logic        vld_reg;

    always_comb
    begin
        trial  = {1'b0, d_in.root} + STEP_BIT;
        take   = {1'b0, d_in.rem_sq} >= trial;
        d_next = d_in;
        if (take)
        begin
            d_next.rem_sq = 63'({1'b0, d_in.rem_sq} - trial);
            d_next.root   = 63'(({1'b0, d_in.root} >> 1) + STEP_BIT);
        end
        else
        begin
            d_next.root = d_in.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
        end
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;

endmodule

// ===== sv/fdm_iter_cell.sv =====
module fdm_iter_cell
    import fdm_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       vld_in,
    input  cell_data_t d_in,
    output logic       vld_out,
    output cell_data_t d_out
);

    localparam int QPOS = DIV_STEPS - 1 - STEP;
    localparam logic signed [32:0] ANGLE = atan_entry(STEP);

    logic signed [40:0] shx;
    logic signed [40:0] shy;
    logic [32:0]        divisor;
    logic [32:0]        shift_x;
    logic [32:0]        shift_y;
    logic               ge_x;
    logic               ge_y;
    cell_data_t         d_next;
    cell_data_t         d_reg;
    logic               vld_reg;

    always_comb
    begin
        d_next = d_in;
        shx    = d_in.cy >>> STEP;
        shy    = d_in.cx >>> STEP;
        if (STEP < CORDIC_ITERS)
        begin
            if (!d_in.cy[40])
            begin
                d_next.cx = d_in.cx + shx;
                d_next.cy = d_in.cy - shy;
                d_next.cz = d_in.cz + ANGLE;
            end
            else
            begin
                d_next.cx = d_in.cx - shx;
                d_next.cy = d_in.cy + shy;
                d_next.cz = d_in.cz - ANGLE;
            end
        end
        // restoring division, one quotient bit per cell
        divisor = {1'b0, d_in.root[31:0]};
        shift_x = {d_in.rem_x, (STEP == 0) ? d_in.mag_x[0] : 1'b0};
        shift_y = {d_in.rem_y, (STEP == 0) ? d_in.mag_y[0] : 1'b0};
        ge_x    = shift_x >= divisor;
        ge_y    = shift_y >= divisor;
        d_next.rem_x = ge_x ? 32'(shift_x - divisor) : shift_x[31:0];
        d_next.rem_y = ge_y ? 32'(shift_y - divisor) : shift_y[31:0];
        d_next.quo_x[QPOS] = ge_x;
        d_next.quo_y[QPOS] = ge_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
        end
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;

endmodule

// ===== sv/fdm_warp.sv =====
module fdm_warp
    import fdm_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            vld_in,
    input  cell_data_t                      d_in,
    input  logic [CFG_DATA_BITS-1:0]        src_focal,
    input  logic [CFG_DATA_BITS-1:0]        src_center,
    input  logic [CFG_DATA_BITS-1:0]        dist_k_low,
    input  logic [CFG_DATA_BITS-1:0]        dist_k_high,
    input  logic [SIZE_BITS-1:0]            size_x,
    input  logic [SIZE_BITS-1:0]            size_y,
    output logic                            vld_out,
    output logic [COORD_BITS+FRAC_BITS-1:0] src_x,
    output logic [COORD_BITS+FRAC_BITS-1:0] src_y,
    output logic                            in_bounds
);

    localparam int OUT_BITS = COORD_BITS + FRAC_BITS;
    localparam int STAGES   = 11;

    typedef struct packed {
        logic [30:0] th;
        logic [30:0] quo_x;
        logic [30:0] quo_y;
        logic        neg_x;
        logic        neg_y;
        logic        r_zero;
    } warp_side_t;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic signed [43:0] apply_sign(input logic neg, input logic [39:0] m);
        return neg ? -$signed({4'b0, m}) : $signed({4'b0, m});
    endfunction

    function automatic logic [40:0] cap40(input logic [45:0] v);
        return (v > {5'b0, MAG_CAP}) ? MAG_CAP : v[40:0];
    endfunction

    function automatic logic [30:0] bound_of(input logic [SIZE_BITS-1:0] sz);
        logic [14:0] lim;
        lim = ({2'b0, sz} > (15'd1 << COORD_BITS)) ? (15'd1 << COORD_BITS) : {2'b0, sz};
        return (lim == 15'd0) ? 31'd0 : {15'(lim - 15'd1), 16'b0};
    endfunction

    logic [STAGES-1:0]  vld_reg;
    warp_side_t         side_in;
    warp_side_t         side_reg [6];

    logic [61:0]        t2p_reg;
    logic [29:0]        t2_reg;
    logic [59:0]        t4p_reg;
    logic [31:0]        t4;
    logic [61:0]        p1_reg;
    logic [63:0]        p2_reg;
    logic [61:0]        t6p_reg;
    logic [63:0]        t8p_reg;
    logic [33:0]        t6;
    logic [35:0]        t8;
    logic [65:0]        p3_reg;
    logic [67:0]        p4_reg;
    logic signed [43:0] term1_reg;
    logic signed [43:0] term2_reg;
    logic signed [43:0] poly_reg;
    logic [42:0]        poly_mag;
    logic [73:0]        thdp_reg;
    logic               neg_thd_reg;
    logic [40:0]        thd;
    logic [71:0]        dpx_reg;
    logic [71:0]        dpy_reg;
    logic               ndx7_reg;
    logic               ndy7_reg;
    logic               rz7_reg;
    logic [40:0]        dmx_reg;
    logic [40:0]        dmy_reg;
    logic               ndx8_reg;
    logic               ndy8_reg;
    logic [72:0]        fpx_reg;
    logic [72:0]        fpy_reg;
    logic               ndx9_reg;
    logic               ndy9_reg;
    logic [40:0]        tmx;
    logic [40:0]        tmy;
    logic signed [42:0] sx_next;
    logic signed [42:0] sy_next;
    logic signed [42:0] sx_reg;
    logic signed [42:0] sy_reg;
    logic signed [42:0] bnd_x;
    logic signed [42:0] bnd_y;
    logic               inside_next;
    logic [OUT_BITS-1:0] src_x_reg;
    logic [OUT_BITS-1:0] src_y_reg;
    logic               inside_reg;

    always_comb
    begin
        side_in.th     = d_in.cz[32] ? 31'd0 : d_in.cz[30:0];
        side_in.quo_x  = d_in.quo_x;
        side_in.quo_y  = d_in.quo_y;
        side_in.neg_x  = d_in.neg_x;
        side_in.neg_y  = d_in.neg_y;
        side_in.r_zero = d_in.root == 63'd0;
    end

    assign t4       = t4p_reg[59:28];
    assign t6       = t6p_reg[61:28];
    assign t8       = t8p_reg[63:28];
    assign poly_mag = poly_reg[43] ? 43'(-poly_reg) : poly_reg[42:0];
    assign thd      = cap40(thdp_reg[73:28]);
    assign tmx      = cap40({3'b0, fpx_reg[72:30]});
    assign tmy      = cap40({3'b0, fpy_reg[72:30]});
    assign sx_next  = $signed({11'b0, src_center[63:32]})
                    + (ndx9_reg ? -$signed({2'b0, tmx}) : $signed({2'b0, tmx}));
    assign sy_next  = $signed({11'b0, src_center[31:0]})
                    + (ndy9_reg ? -$signed({2'b0, tmy}) : $signed({2'b0, tmy}));
    assign bnd_x    = $signed({12'b0, bound_of(size_x)});
    assign bnd_y    = $signed({12'b0, bound_of(size_y)});
    assign inside_next = (sx_reg > 43'sd0) && (sy_reg > 43'sd0)
                       && (sx_reg < bnd_x) && (sy_reg < bnd_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < 6; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            // theta powers
            t2p_reg <= 62'(side_in.th) * 62'(side_in.th);
            t2_reg  <= t2p_reg[61:32];
            t4p_reg <= 60'(t2p_reg[61:32]) * 60'(t2p_reg[61:32]);
            p1_reg  <= 62'(abs32(dist_k_low[63:32])) * 62'(t2_reg);
            p2_reg  <= 64'(abs32(dist_k_low[31:0])) * 64'(t4);
            t6p_reg <= 62'(t2_reg) * 62'(t4);
            t8p_reg <= 64'(t4) * 64'(t4);
            p3_reg  <= 66'(abs32(dist_k_high[63:32])) * 66'(t6);
            p4_reg  <= 68'(abs32(dist_k_high[31:0])) * 68'(t8);
            term1_reg <= apply_sign(dist_k_low[63], {6'b0, p1_reg[61:28]});
            term2_reg <= apply_sign(dist_k_low[31], {4'b0, p2_reg[63:28]});
            // polynomial and theta_d
            poly_reg <= (44'sd1 <<< 28) + term1_reg + term2_reg
                      + apply_sign(dist_k_high[63], {2'b0, p3_reg[65:28]})
                      + apply_sign(dist_k_high[31], p4_reg[67:28]);
            thdp_reg    <= 74'(poly_mag) * 74'(side_reg[4].th);
            neg_thd_reg <= poly_reg[43];
            // per-axis scaling
            dpx_reg  <= 72'(thd) * 72'(side_reg[5].quo_x);
            dpy_reg  <= 72'(thd) * 72'(side_reg[5].quo_y);
            ndx7_reg <= neg_thd_reg ^ side_reg[5].neg_x;
            ndy7_reg <= neg_thd_reg ^ side_reg[5].neg_y;
            rz7_reg  <= side_reg[5].r_zero;
            dmx_reg  <= rz7_reg ? 41'd0 : cap40({4'b0, dpx_reg[71:30]});
            dmy_reg  <= rz7_reg ? 41'd0 : cap40({4'b0, dpy_reg[71:30]});
            ndx8_reg <= ndx7_reg;
            ndy8_reg <= ndy7_reg;
            fpx_reg  <= 73'(dmx_reg) * 73'(src_focal[63:32]);
            fpy_reg  <= 73'(dmy_reg) * 73'(src_focal[31:0]);
            ndx9_reg <= ndx8_reg;
            ndy9_reg <= ndy8_reg;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            inside_reg <= inside_next;
            src_x_reg  <= inside_next ? sx_reg[16-FRAC_BITS +: OUT_BITS] : '0;
            src_y_reg  <= inside_next ? sy_reg[16-FRAC_BITS +: OUT_BITS] : '0;
        end
    end

    assign vld_out   = vld_reg[STAGES-1];
    assign src_x     = src_x_reg;
    assign src_y     = src_y_reg;
    assign in_bounds = inside_reg;

endmodule

// ===== sv/fisheye_distortion_map.sv =====
// Equidistant fisheye remap: one rectified pixel (out_x, out_y) in, one source
// coordinate (src_x, src_y in Q COORD_BITS.FRAC_BITS) and an inside flag out.
// Fully pipelined, one item per clock unless stalled: 4 normalize stages, 32
// square-root cells, 31 cells that each do one quotient bit of the two radius
// divisions (the first CORDIC_ITERS also one CORDIC atan step), and 11 stages of
// polynomial, scaling and bound test. A stalled output freezes the whole pipeline.
// Configuration writes are taken at any time but must only happen while idle.
module fisheye_distortion_map
    import fdm_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [COORD_BITS-1:0]           out_x,
    input  logic [COORD_BITS-1:0]           out_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [COORD_BITS+FRAC_BITS-1:0] src_x,
    output logic [COORD_BITS+FRAC_BITS-1:0] src_y,
    output logic                            inside_res,
    input  logic                            cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]        cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]        cfg_data
);

    logic [CFG_DATA_BITS-1:0] src_focal_reg;
    logic [CFG_DATA_BITS-1:0] src_center_reg;
    logic [CFG_DATA_BITS-1:0] dist_k_low_reg;
    logic [CFG_DATA_BITS-1:0] dist_k_high_reg;
    logic [CFG_DATA_BITS-1:0] rect_inv_focal_reg;
    logic [CFG_DATA_BITS-1:0] rect_center_reg;
    logic [SIZE_BITS-1:0]     src_width_reg;
    logic [SIZE_BITS-1:0]     src_height_reg;

    logic        adv;
    logic [3:0]  f_vld_reg;
    logic [33:0] dx;
    logic [33:0] dy;
    logic [31:0] dmx_reg;
    logic [31:0] dmy_reg;
    logic [3:0]  nx_reg;
    logic [3:0]  ny_reg;
    logic [63:0] ipx_reg;
    logic [63:0] ipy_reg;
    logic [30:0] mx_reg;
    logic [30:0] my_reg;
    logic [30:0] mx4_reg;
    logic [30:0] my4_reg;
    logic [61:0] sqx_reg;
    logic [61:0] sqy_reg;

    cell_data_t  sq_head;
    cell_data_t  it_head;
    cell_data_t  sq_data [SQRT_STEPS+1];
    logic        sq_vld  [SQRT_STEPS+1];
    cell_data_t  it_data [DIV_STEPS+1];
    logic        it_vld  [DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_focal_reg      <= '0;
            src_center_reg     <= '0;
            dist_k_low_reg     <= '0;
            dist_k_high_reg    <= '0;
            rect_inv_focal_reg <= '0;
            rect_center_reg    <= '0;
            src_width_reg      <= 13'd640;
            src_height_reg     <= 13'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SRC_FOCAL:      src_focal_reg      <= cfg_data;
                REG_SRC_CENTER:     src_center_reg     <= cfg_data;
                REG_DIST_K_LOW:     dist_k_low_reg     <= cfg_data;
                REG_DIST_K_HIGH:    dist_k_high_reg    <= cfg_data;
                REG_RECT_INV_FOCAL: rect_inv_focal_reg <= cfg_data;
                REG_RECT_CENTER:    rect_center_reg    <= cfg_data;
                REG_SRC_WIDTH:      src_width_reg      <= cfg_data[SIZE_BITS-1:0];
                REG_SRC_HEIGHT:     src_height_reg     <= cfg_data[SIZE_BITS-1:0];
                default:            ;
            endcase
        end
    end

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // offset from the rectified center, Q16.16
    assign dx = {{(18-COORD_BITS){1'b0}}, out_x, 16'h0}
              - {{2{rect_center_reg[63]}}, rect_center_reg[63:32]};
    assign dy = {{(18-COORD_BITS){1'b0}}, out_y, 16'h0}
              - {{2{rect_center_reg[31]}}, rect_center_reg[31:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= '0;
        end
        else if (adv)
        begin
            f_vld_reg <= {f_vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmx_reg <= dx[33] ? 32'(-dx) : dx[31:0];
            dmy_reg <= dy[33] ? 32'(-dy) : dy[31:0];
            nx_reg  <= {nx_reg[2:0], dx[33]};
            ny_reg  <= {ny_reg[2:0], dy[33]};
            ipx_reg <= 64'(dmx_reg) * 64'(rect_inv_focal_reg[63:32]);
            ipy_reg <= 64'(dmy_reg) * 64'(rect_inv_focal_reg[31:0]);
            mx_reg  <= (|ipx_reg[63:51]) ? 31'h7FFF_FFFF : ipx_reg[50:20];
            my_reg  <= (|ipy_reg[63:51]) ? 31'h7FFF_FFFF : ipy_reg[50:20];
            mx4_reg <= mx_reg;
            my4_reg <= my_reg;
            sqx_reg <= 62'(mx_reg) * 62'(mx_reg);
            sqy_reg <= 62'(my_reg) * 62'(my_reg);
        end
    end

    always_comb
    begin
        sq_head        = '0;
        sq_head.neg_x  = nx_reg[3];
        sq_head.neg_y  = ny_reg[3];
        sq_head.mag_x  = mx4_reg;
        sq_head.mag_y  = my4_reg;
        sq_head.rem_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    assign sq_data[0] = sq_head;
    assign sq_vld[0]  = f_vld_reg[3];

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        fdm_sqrt_cell #(.STEP(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .vld_in  (sq_vld[i]),
            .d_in    (sq_data[i]),
            .vld_out (sq_vld[i+1]),
            .d_out   (sq_data[i+1])
        );
    end

    // CORDIC starts at (2^30, r * 2^6); dividers start from mag >> 1
    always_comb
    begin
        it_head       = sq_data[SQRT_STEPS];
        it_head.cx    = 41'sd1 <<< 30;
        it_head.cy    = $signed({3'b0, sq_data[SQRT_STEPS].root[31:0], 6'b0});
        it_head.cz    = '0;
        it_head.rem_x = {2'b0, sq_data[SQRT_STEPS].mag_x[30:1]};
        it_head.rem_y = {2'b0, sq_data[SQRT_STEPS].mag_y[30:1]};
        it_head.quo_x = '0;
        it_head.quo_y = '0;
    end

    assign it_data[0] = it_head;
    assign it_vld[0]  = sq_vld[SQRT_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_iter
        fdm_iter_cell #(.STEP(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .vld_in  (it_vld[i]),
            .d_in    (it_data[i]),
            .vld_out (it_vld[i+1]),
            .d_out   (it_data[i+1])
        );
    end

    fdm_warp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_warp (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .vld_in      (it_vld[DIV_STEPS]),
        .d_in        (it_data[DIV_STEPS]),
        .src_focal   (src_focal_reg),
        .src_center  (src_center_reg),
        .dist_k_low  (dist_k_low_reg),
        .dist_k_high (dist_k_high_reg),
        .size_x      (src_width_reg),
        .size_y      (src_height_reg),
        .vld_out     (out_valid),
        .src_x       (src_x),
        .src_y       (src_y),
        .in_bounds   (inside_res)
    );

    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld[SQRT_STEPS] |->
            sq_data[SQRT_STEPS].rem_sq <= {sq_data[SQRT_STEPS].root[61:0], 1'b0})
        else $error("sqrt remainder exceeds 2*root");

    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (it_vld[DIV_STEPS] && it_data[DIV_STEPS].root != 63'd0) |->
            (it_data[DIV_STEPS].quo_x <= 31'h4000_0000)
            && (it_data[DIV_STEPS].quo_y <= 31'h4000_0000))
        else $error("radius quotient above one");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (it_vld[DIV_STEPS] && it_data[DIV_STEPS].root != 63'd0) |->
            (it_data[DIV_STEPS].rem_x < it_data[DIV_STEPS].root[31:0])
            && (it_data[DIV_STEPS].rem_y < it_data[DIV_STEPS].root[31:0]))
        else $error("division remainder not below divisor");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !inside_res) |-> (src_x == '0) && (src_y == '0))
        else $error("outside item with nonzero coordinate");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import fdm_pkg::*;

    localparam int CB = 12;
    localparam int FB = 8;
    localparam logic [63:0] PROD_CAP = 64'h100_0000_0000;
    localparam logic [63:0] NORM_CAP = 64'h7FFF_FFFF;
    localparam logic [CFG_ADDR_BITS-1:0] REG_NONE = 4'd11;
    localparam int DRAIN_CYCLES = 90;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [CB+FB-1:0] sx;
        logic [CB+FB-1:0] sy;
        logic             in_bounds;
    } remap_t;

    typedef struct {
        logic [CB-1:0]    px;
        logic [CB-1:0]    py;
        logic             typed;
        logic [CB+FB-1:0] ex;
        logic [CB+FB-1:0] ey;
        logic             ein;
    } row_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready, inside_res;
    logic [CB-1:0] out_x, out_y;
    logic [CB+FB-1:0] src_x, src_y;
    logic cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    logic [63:0] regs_q [8];
    longint atan_q30_tab [CORDIC_ITERS];
    remap_t remap_q [$];
    int errors = 0;
    int send_idle_pct = 0, recv_idle_pct = 0, hold_off = 0;

    fisheye_distortion_map #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] mul_cap(logic [63:0] a, logic [63:0] b, int s,
                                            logic [63:0] cap);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> s;
        if (p > {64'd0, cap})
            return cap;
        return p[63:0];
    endfunction

    function automatic longint smul_cap(longint a, logic [63:0] b, int s, logic [63:0] cap);
        longint m;
        m = longint'(mul_cap(a < 0 ? -a : a, b, s, cap));
        return a < 0 ? -m : m;
    endfunction

    function automatic longint sext32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint atan_recip(longint unsigned n);
        longint unsigned p, nn, k;
        longint sum, term;
        p = (64'd1 << 62) / n;
        nn = n * n;
        sum = 0;
        k = 0;
        while (p != 0)
        begin
            term = longint'(p / (2 * k + 1));
            sum = k[0] ? sum - term : sum + term;
            p = p / nn;
            k++;
        end
        return sum;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] arctan(logic [63:0] r);
        longint x, y, z, tx, ty;
        x = longint'(1) << 30;
        y = longint'(r << 6);
        z = 0;
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            tx = y >>> i;
            ty = x >>> i;
            if (y >= 0)
            begin
                x += tx; y -= ty; z += atan_q30_tab[i];
            end
            else
            begin
                x -= tx; y += ty; z -= atan_q30_tab[i];
            end
        end
        return z < 0 ? 64'd0 : z;
    endfunction

    function automatic longint bend_axis(longint thd, longint iv, logic [63:0] r);
        logic [63:0] u;
        longint d;
        u = ((iv < 0 ? -iv : iv) << 30) / r;
        d = smul_cap(thd, u, 30, PROD_CAP);
        return iv < 0 ? -d : d;
    endfunction

    function automatic longint edge_limit(logic [63:0] sz);
        logic [63:0] lim;
        lim = sz > 4096 ? 64'd4096 : sz;
        return lim >= 1 ? longint'((lim - 1) << 16) : 0;
    endfunction

    function automatic remap_t predict_remap(logic [CB-1:0] px, logic [CB-1:0] py);
        longint dx, dy, ix, iy, mx, my, xd, yd, sx, sy, poly, thd;
        logic [63:0] r, th, t2, t4, t6, t8;
        remap_t res;
        dx = longint'({px, 16'd0}) - sext32(regs_q[REG_RECT_CENTER][63:32]);
        dy = longint'({py, 16'd0}) - sext32(regs_q[REG_RECT_CENTER][31:0]);
        ix = smul_cap(dx, regs_q[REG_RECT_INV_FOCAL][63:32], 20, NORM_CAP);
        iy = smul_cap(dy, regs_q[REG_RECT_INV_FOCAL][31:0], 20, NORM_CAP);
        mx = ix < 0 ? -ix : ix;
        my = iy < 0 ? -iy : iy;
        r = int_sqrt(mx * mx + my * my);
        xd = 0;
        yd = 0;
        if (r != 0)
        begin
            th = arctan(r);
            t2 = mul_cap(th, th, 32, PROD_CAP);
            t4 = mul_cap(t2, t2, 28, PROD_CAP);
            t6 = mul_cap(t2, t4, 28, PROD_CAP);
            t8 = mul_cap(t4, t4, 28, PROD_CAP);
            poly = (longint'(1) << 28)
                + smul_cap(sext32(regs_q[REG_DIST_K_LOW][63:32]), t2, 28, PROD_CAP)
                + smul_cap(sext32(regs_q[REG_DIST_K_LOW][31:0]), t4, 28, PROD_CAP)
                + smul_cap(sext32(regs_q[REG_DIST_K_HIGH][63:32]), t6, 28, PROD_CAP)
                + smul_cap(sext32(regs_q[REG_DIST_K_HIGH][31:0]), t8, 28, PROD_CAP);
            thd = smul_cap(poly, th, 28, PROD_CAP);
            xd = bend_axis(thd, ix, r);
            yd = bend_axis(thd, iy, r);
        end
        sx = longint'({32'd0, regs_q[REG_SRC_CENTER][63:32]})
            + smul_cap(xd, regs_q[REG_SRC_FOCAL][63:32], 30, PROD_CAP);
        sy = longint'({32'd0, regs_q[REG_SRC_CENTER][31:0]})
            + smul_cap(yd, regs_q[REG_SRC_FOCAL][31:0], 30, PROD_CAP);
        if (sx > 0 && sy > 0 && sx < edge_limit(regs_q[REG_SRC_WIDTH])
            && sy < edge_limit(regs_q[REG_SRC_HEIGHT]))
        begin
            res.sx = (CB+FB)'(sx >>> (16 - FB));
            res.sy = (CB+FB)'(sy >>> (16 - FB));
            res.in_bounds = 1'b1;
        end
        else
        begin
            res.sx = '0;
            res.sy = '0;
            res.in_bounds = 1'b0;
        end
        return res;
    endfunction

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx <= REG_SRC_HEIGHT)
            regs_q[idx] = (idx >= REG_SRC_WIDTH) ? (val & 64'h1FFF) : val;
        @(posedge clk);
    endtask

    task automatic load_config(logic [63:0] f, logic [63:0] c, logic [63:0] kl,
                               logic [63:0] kh, logic [63:0] inv, logic [63:0] rc,
                               logic [63:0] w, logic [63:0] h);
        write_reg(REG_SRC_FOCAL, f);
        write_reg(REG_SRC_CENTER, c);
        write_reg(REG_DIST_K_LOW, kl);
        write_reg(REG_DIST_K_HIGH, kh);
        write_reg(REG_RECT_INV_FOCAL, inv);
        write_reg(REG_RECT_CENTER, rc);
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
    endtask

    // plausible camera: random focal, centers near mid-image, small distortion
    task automatic load_camera(int w, int h);
        logic [31:0] fs, fr, k [4];
        fs = $urandom_range(120, 700) << 16 | $urandom_range(0, 65535);
        fr = $urandom_range(120, 700);
        for (int i = 0; i < 4; i++)
            k[i] = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        load_config({fs, fs + $urandom_range(0, 32'h0008_0000)},
                    {32'(w / 2 + $urandom_range(0, 20)) << 16 | $urandom_range(0, 65535),
                     32'(h / 2 + $urandom_range(0, 20)) << 16 | $urandom_range(0, 65535)},
                    {k[0], k[1]}, {k[2], k[3]},
                    {32'(268435456 / fr), 32'(268435456 / (fr + $urandom_range(0, 40)))},
                    {32'(w / 2) << 16, 32'(h / 2) << 16}, w, h);
    endtask

    task automatic drain();
        while (remap_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixel(logic [CB-1:0] px, logic [CB-1:0] py);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        out_x <= px;
        out_y <= py;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_checked(logic [CB-1:0] px, logic [CB-1:0] py);
        send_pixel(px, py);
        remap_q.push_back(predict_remap(px, py));
    endtask

    task automatic send_random(int n, int span_x, int span_y);
        logic [CB-1:0] px, py;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                px = CB'($urandom);
                py = CB'($urandom);
            end
            else
            begin
                px = CB'($urandom_range(0, span_x));
                py = CB'($urandom_range(0, span_y));
            end
            send_checked(px, py);
        end
        in_valid <= 1'b0;
    endtask

    task automatic run_rows(row_t rows []);
        remap_t e;
        foreach (rows[i])
        begin
            send_pixel(rows[i].px, rows[i].py);
            if (rows[i].typed)
            begin
                e.sx = rows[i].ex;
                e.sy = rows[i].ey;
                e.in_bounds = rows[i].ein;
                remap_q.push_back(e);
            end
            else
                remap_q.push_back(predict_remap(rows[i].px, rows[i].py));
        end
        in_valid <= 1'b0;
    endtask

    // result side: compare, then choose next ready
    initial
    begin
        remap_t e;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (remap_q.size() == 0)
                begin
                    $error("unexpected item src_x=%0h src_y=%0h", src_x, src_y);
                    errors++;
                end
                else
                begin
                    e = remap_q.pop_front();
                    if (src_x !== e.sx)
                    begin
                        $error("src_x expected %0h actual %0h", e.sx, src_x);
                        errors++;
                    end
                    if (src_y !== e.sy)
                    begin
                        $error("src_y expected %0h actual %0h", e.sy, src_y);
                        errors++;
                    end
                    if (inside_res !== e.in_bounds)
                    begin
                        $error("inside_res expected %0b actual %0b", e.in_bounds, inside_res);
                        errors++;
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else if (++quiet >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        longint v;
        row_t reset_rows [] = '{
            '{12'd0,    12'd0,    1'b1, 20'd0, 20'd0, 1'b0},
            '{12'd4095, 12'd4095, 1'b1, 20'd0, 20'd0, 1'b0},
            '{12'd0,    12'd4095, 1'b1, 20'd0, 20'd0, 1'b0},
            '{12'd4095, 12'd0,    1'b1, 20'd0, 20'd0, 1'b0}
        };
        row_t nominal_rows [] = '{
            '{12'd320,  12'd240,  1'b1, 20'd81920, 20'd61440, 1'b1},
            '{12'd321,  12'd240,  1'b0, 20'd0, 20'd0, 1'b0},
            '{12'd320,  12'd241,  1'b0, 20'd0, 20'd0, 1'b0},
            '{12'd0,    12'd0,    1'b0, 20'd0, 20'd0, 1'b0},
            '{12'd639,  12'd479,  1'b0, 20'd0, 20'd0, 1'b0},
            '{12'd0,    12'd479,  1'b0, 20'd0, 20'd0, 1'b0},
            '{12'd639,  12'd0,    1'b0, 20'd0, 20'd0, 1'b0},
            '{12'd4095, 12'd4095, 1'b1, 20'd0, 20'd0, 1'b0},
            '{12'd4095, 12'd240,  1'b1, 20'd0, 20'd0, 1'b0},
            '{12'd2730, 12'd1365, 1'b0, 20'd0, 20'd0, 1'b0},
            '{12'd100,  12'd400,  1'b0, 20'd0, 20'd0, 1'b0},
            '{12'd500,  12'd50,   1'b0, 20'd0, 20'd0, 1'b0}
        };

        v = 4 * atan_recip(5) - atan_recip(239);
        atan_q30_tab[0] = (v + (longint'(1) << 31)) >>> 32;
        for (int i = 1; i < CORDIC_ITERS; i++)
            atan_q30_tab[i] = (atan_recip(longint'(1) << i) + (longint'(1) << 31)) >>> 32;
        for (int i = 0; i < 8; i++)
            regs_q[i] = '0;
        regs_q[REG_SRC_WIDTH] = 640;
        regs_q[REG_SRC_HEIGHT] = 480;

        rst_n = 1'b0;
        in_valid = 1'b0;
        out_x = '0;
        out_y = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 52;
        run_rows(reset_rows);
        drain();

        // 300 px focal on both cameras, no distortion terms
        load_config({32'd300 << 16, 32'd300 << 16}, {32'd320 << 16, 32'd240 << 16},
                    64'd0, 64'd0, {32'd894784, 32'd894784},
                    {32'd320 << 16, 32'd240 << 16}, 640, 480);
        run_rows(nominal_rows);
        drain();
        write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        hold_off = 400;
        send_random(200, 700, 520);
        drain();

        load_camera($urandom_range(2, 4096), $urandom_range(2, 4096));
        send_random(150, 4095, 4095);
        drain();

        send_idle_pct = 52;
        recv_idle_pct = 38;
        load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    $urandom, $urandom);
        send_random(120, 4095, 4095);
        drain();

        load_config('1, '1, '1, '1, '1, '1, 13'h1FFF, 4096);
        send_random(60, 4095, 4095);
        drain();

        load_config('0, '0, '0, '0, '0, '0, 0, 0);
        send_random(30, 4095, 4095);
        drain();

        load_camera(2, 1);
        send_random(40, 8, 8);
        drain();

        load_camera(2, 2);
        write_reg(REG_SRC_CENTER, {32'h0000_8000, 32'h0000_8000});
        send_random(40, 8, 8);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int p = 0; p < 4; p++)
        begin
            load_camera($urandom_range(64, 1600), $urandom_range(64, 1200));
            send_random(100, 1700, 1300);
            drain();
        end

        load_camera(4096, 4096);
        send_random(50, 4095, 4095);
        drain();

        if (errors == 0 && remap_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
